// File: rtl/core/swdc_pkg.sv
// Shared types and constants for the sliding-window distinct counter.
// Used by swdc_cnt_unit and sliding_window_distinct_count_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package swdc_pkg;

  // fixed field widths
  localparam int POS_W     = 11;
  localparam int VAL_W     = 10;
  localparam int CNT_OUT_W = 11;
  localparam int OP_W      = 2;
  localparam int STS_W     = 2;

  // stream word widths
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 16;

  // highest position a field can carry, and values a field can carry
  localparam int POS_MAX   = (1 << POS_W) - 1;
  localparam int VAL_SPAN  = 1 << VAL_W;

  // parameter defaults
  localparam int ARRAY_DEPTH_DEF = 1024;
  localparam int VALUE_RANGE_DEF = 1024;

  // reset value of the length register
  localparam logic [POS_W-1:0] LEN_RESET = 11'd1024;

  // op codes
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // status codes
  localparam logic [STS_W-1:0] STS_OK     = 2'd0;
  localparam logic [STS_W-1:0] STS_BOUNDS = 2'd1;
  localparam logic [STS_W-1:0] STS_REJECT = 2'd2;

  // one window step handed to the count unit with the element value
  typedef struct packed {
    logic vld;
    logic add;   // 1: value enters window, 0: value leaves
  } cnt_step_t;

  // count unit status back to the sequencer
  typedef struct packed {
    logic init_done;   // reset clearing of the count table finished
    logic pipe_busy;   // an update is still in flight
  } cnt_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/swdc_cnt_unit.sv
// Per-value occurrence count table with read-modify-write and forwarding.
// Keeps the running distinct total. Depends on swdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swdc_cnt_unit #(
  parameter int ARRAY_DEPTH = swdc_pkg::ARRAY_DEPTH_DEF,
  parameter int VALUE_RANGE = swdc_pkg::VALUE_RANGE_DEF,
  localparam int CNT_DEPTH  = (VALUE_RANGE < swdc_pkg::VAL_SPAN) ? VALUE_RANGE
                                                                 : swdc_pkg::VAL_SPAN,
  localparam int ST_DEPTH   = (ARRAY_DEPTH < swdc_pkg::POS_MAX) ? ARRAY_DEPTH
                                                                : swdc_pkg::POS_MAX,
  localparam int CW         = $clog2(CNT_DEPTH),
  localparam int NW         = $clog2(ST_DEPTH + 1)
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  swdc_pkg::cnt_step_t  step_i,
  input  wire  [CW-1:0]        value_i,
  output logic [NW-1:0]        total_o,
  output swdc_pkg::cnt_stat_t  stat_o
);
  import swdc_pkg::*;

  localparam logic [CW-1:0] LAST_ADDR = CW'(CNT_DEPTH - 1);

  logic [NW-1:0] cnt_mem [CNT_DEPTH];

  logic          init_r;
  logic [CW-1:0] init_addr_r;

  // update stage
  logic          b_vld_r;
  logic          b_add_r;
  logic [CW-1:0] b_val_r;
  logic [NW-1:0] rd_r;

  // last write, for a read that raced it
  logic          wr_vld_r;
  logic [CW-1:0] wr_addr_r;
  logic [NW-1:0] wr_data_r;

  logic [NW-1:0] total_r;
  logic [NW-1:0] total_nxt;

  logic [NW-1:0] cur_cnt;
  logic [NW-1:0] cnt_nxt;
  logic          mem_we;
  logic [CW-1:0] mem_waddr;
  logic [NW-1:0] mem_wdata;

  always_comb begin
    cur_cnt = (wr_vld_r && (wr_addr_r == b_val_r)) ? wr_data_r : rd_r;
    cnt_nxt = b_add_r ? cur_cnt + NW'(1) : cur_cnt - NW'(1);
    total_nxt = total_r;
    if (b_vld_r) begin
      if (b_add_r && (cur_cnt == '0)) begin
        total_nxt = total_r + NW'(1);
      end else if (!b_add_r && (cur_cnt == NW'(1))) begin
        total_nxt = total_r - NW'(1);
      end
    end
    mem_we    = init_r || b_vld_r;
    mem_waddr = init_r ? init_addr_r : b_val_r;
    mem_wdata = init_r ? '0 : cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cnt_mem[mem_waddr] <= mem_wdata;
    end
    rd_r <= cnt_mem[value_i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r      <= 1'b1;
      init_addr_r <= '0;
      b_vld_r     <= 1'b0;
      wr_vld_r    <= 1'b0;
      total_r     <= '0;
    end else begin
      if (init_r) begin
        init_addr_r <= init_addr_r + CW'(1);
        if (init_addr_r == LAST_ADDR) begin
          init_r <= 1'b0;
        end
      end
      b_vld_r  <= step_i.vld;
      wr_vld_r <= b_vld_r;
      total_r  <= total_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    b_add_r   <= step_i.add;
    b_val_r   <= value_i;
    wr_addr_r <= b_val_r;
    wr_data_r <= cnt_nxt;
  end

  assign total_o          = total_r;
  assign stat_o.init_done = !init_r;
  assign stat_o.pipe_busy = b_vld_r;

endmodule

`default_nettype wire

// File: rtl/core/sliding_window_distinct_count_top.sv
// Top level of the sliding-window distinct counter: stream ports, element
// store, window sequencer. Depends on swdc_pkg and swdc_cnt_unit.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Ports                                   Contents
// in_       in   in_tvalid/in_tready/in_tdata/in_tuser    one command word
// out_      out  out_tvalid/out_tready/out_tdata          one result per command
// cfg_      in   cfg_wr_en/cfg_wr_data                    length_in_use
//
// Sequence: a write or a rejected command goes from S_EXEC straight to S_RESP;
//   a query or a clear runs S_EXEC, S_MOVE for n window steps, n = |dl| + |dr|
//   for a query (the window size for a clear), then S_DRAIN and S_RESP.
//   in_tready returns at the edge that raises out_tvalid. One window step a
//   cycle: element store read, then count table read-modify-write, with the
//   last write forwarded.
// Reset: clears control state, then sweeps zeros into the element store and
//   count table, with in_tready low. Config writes are taken during the sweep.
// Stalls: one command at a time; the next word is taken while the result
//   still waits in the output register.

module sliding_window_distinct_count_top #(
  parameter int ARRAY_DEPTH = swdc_pkg::ARRAY_DEPTH_DEF,
  parameter int VALUE_RANGE = swdc_pkg::VALUE_RANGE_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // command stream
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  // [10:0] position, [20:11] value, [31:21] left_end, [42:32] right_end
  input  wire  [swdc_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [1:0] op
  input  wire  [swdc_pkg::OP_W-1:0]           in_tuser,
  // result stream
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // [10:0] distinct_count, [12:11] status
  output logic [swdc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // length register
  input  wire                                 cfg_wr_en,
  input  wire  [swdc_pkg::POS_W-1:0]          cfg_wr_data
);
  import swdc_pkg::*;

  // store holds at most as many positions as a field can address
  localparam int ST_DEPTH  = (ARRAY_DEPTH < POS_MAX) ? ARRAY_DEPTH : POS_MAX;
  localparam int CNT_DEPTH = (VALUE_RANGE < VAL_SPAN) ? VALUE_RANGE : VAL_SPAN;
  localparam int AW        = $clog2(ST_DEPTH);
  localparam int CW        = $clog2(CNT_DEPTH);
  localparam int NW        = $clog2(ST_DEPTH + 1);

  localparam logic [POS_W-1:0] EFF_CAP   = POS_W'(ST_DEPTH);
  localparam logic [VAL_W:0]   VAL_LIMIT = (VAL_W + 1)'(CNT_DEPTH);
  localparam logic [AW-1:0]    ST_LAST   = AW'(ST_DEPTH - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_MOVE,
    S_DRAIN,
    S_RESP
  } state_t;

  state_t state_r;

  // config
  logic [POS_W-1:0] len_r;
  logic [POS_W-1:0] eff_len;

  // latched command; ql/qr double as the window target
  logic [OP_W-1:0]  op_r;
  logic [POS_W-1:0] pos_r;
  logic [VAL_W-1:0] val_r;
  logic [POS_W-1:0] ql_r;
  logic [POS_W-1:0] qr_r;

  // window
  logic [POS_W-1:0] wl_r;
  logic [POS_W-1:0] wr_r;

  // result staging and output register
  logic [CNT_OUT_W-1:0] res_cnt_r;
  logic [STS_W-1:0]     res_sts_r;
  logic                 out_vld_r;
  logic [CNT_OUT_W-1:0] out_cnt_r;
  logic [STS_W-1:0]     out_sts_r;

  // element store
  logic [CW-1:0] st_mem [ST_DEPTH];
  logic [CW-1:0] st_rd_r;
  logic [AW-1:0] st_clr_r;
  logic          st_clr_busy_r;
  logic          st_we;
  logic [AW-1:0] st_waddr;
  logic [CW-1:0] st_wdata;
  logic [AW-1:0] st_raddr;

  // read stage of a window step
  logic a_vld_r;
  logic a_add_r;

  // step selection
  logic             mv_go;
  logic             mv_add;
  logic [POS_W-1:0] mv_pos;
  logic [POS_W-1:0] mv_pos_m1;
  logic [POS_W-1:0] wpos_m1;

  // command checks
  logic wr_bad;
  logic wr_in_win;
  logic q_bad;

  cnt_step_t     step;
  cnt_stat_t     cstat;
  logic [NW-1:0] total;

  assign eff_len = (len_r < EFF_CAP) ? len_r : EFF_CAP;

  always_comb begin
    wr_bad    = (pos_r == '0) || (pos_r > eff_len) || ({1'b0, val_r} >= VAL_LIMIT);
    wr_in_win = (pos_r >= wl_r) && (pos_r <= wr_r);
    q_bad     = (ql_r == '0) || ({1'b0, ql_r} > ({1'b0, qr_r} + (POS_W + 1)'(1)))
                || (qr_r > eff_len);
  end

  // extend left, extend right, shrink left, shrink right
  always_comb begin
    mv_go  = 1'b1;
    mv_add = 1'b1;
    mv_pos = wl_r;
    priority if (ql_r < wl_r) begin
      mv_pos = wl_r - POS_W'(1);
    end else if (qr_r > wr_r) begin
      mv_pos = wr_r + POS_W'(1);
    end else if (ql_r > wl_r) begin
      mv_add = 1'b0;
      mv_pos = wl_r;
    end else if (qr_r < wr_r) begin
      mv_add = 1'b0;
      mv_pos = wr_r;
    end else begin
      mv_go = 1'b0;
    end
  end

  assign mv_pos_m1 = mv_pos - POS_W'(1);
  assign wpos_m1   = pos_r - POS_W'(1);
  assign st_raddr  = mv_pos_m1[AW-1:0];

  always_comb begin
    st_we    = st_clr_busy_r;
    st_waddr = st_clr_r;
    st_wdata = '0;
    if ((state_r == S_EXEC) && (op_r == OP_WRITE) && !wr_bad && !wr_in_win) begin
      st_we    = 1'b1;
      st_waddr = wpos_m1[AW-1:0];
      st_wdata = val_r[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    st_rd_r <= st_mem[st_raddr];
  end

  // reset sweep of the element store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_clr_busy_r <= 1'b1;
      st_clr_r      <= '0;
    end else if (st_clr_busy_r) begin
      st_clr_r <= st_clr_r + AW'(1);
      if (st_clr_r == ST_LAST) begin
        st_clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_RESET;
    end else if (cfg_wr_en) begin
      len_r <= cfg_wr_data;
    end
  end

  assign step.vld = a_vld_r;
  assign step.add = a_add_r;

  swdc_cnt_unit #(
    .ARRAY_DEPTH (ARRAY_DEPTH),
    .VALUE_RANGE (VALUE_RANGE)
  ) u_cnt (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_i  (step),
    .value_i (st_rd_r),
    .total_o (total),
    .stat_o  (cstat)
  );

  // control FSM and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      wl_r      <= POS_W'(1);
      wr_r      <= '0;
      a_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      a_vld_r <= 1'b0;
      if (out_vld_r && out_tready) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          if (!st_clr_busy_r && cstat.init_done) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_tvalid) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r <= S_RESP;
          unique case (op_r)
            OP_QUERY: begin
              if (!q_bad) begin
                state_r <= S_MOVE;
              end
            end
            OP_CLEAR: begin
              // shrink to an empty window at the left end
              state_r <= S_MOVE;
            end
            default: ;
          endcase
        end
        S_MOVE: begin
          if (mv_go) begin
            a_vld_r <= 1'b1;
            priority if (ql_r < wl_r) begin
              wl_r <= mv_pos;
            end else if (qr_r > wr_r) begin
              wr_r <= mv_pos;
            end else if (ql_r > wl_r) begin
              wl_r <= wl_r + POS_W'(1);
            end else begin
              wr_r <= wr_r - POS_W'(1);
            end
          end else begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!a_vld_r && !cstat.pipe_busy) begin
            state_r <= S_RESP;
            if (op_r == OP_CLEAR) begin
              wl_r <= POS_W'(1);
              wr_r <= '0;
            end
          end
        end
        S_RESP: begin
          if (!out_vld_r || out_tready) begin
            out_vld_r <= 1'b1;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_CLEAR;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    a_add_r <= mv_add;
    if ((state_r == S_IDLE) && in_tvalid) begin
      op_r  <= in_tuser;
      pos_r <= in_tdata[10:0];
      val_r <= in_tdata[20:11];
      ql_r  <= in_tdata[31:21];
      qr_r  <= in_tdata[42:32];
    end
    if (state_r == S_EXEC) begin
      res_cnt_r <= '0;
      res_sts_r <= STS_OK;
      unique case (op_r)
        OP_WRITE: begin
          if (wr_bad) begin
            res_sts_r <= STS_BOUNDS;
          end else if (wr_in_win) begin
            res_sts_r <= STS_REJECT;
          end
        end
        OP_QUERY: begin
          if (q_bad) begin
            res_sts_r <= STS_BOUNDS;
          end
        end
        OP_CLEAR: begin
          ql_r <= wl_r;
          qr_r <= wl_r - POS_W'(1);
        end
        default: res_sts_r <= STS_BOUNDS;
      endcase
    end
    if ((state_r == S_DRAIN) && (op_r == OP_QUERY)) begin
      res_cnt_r <= CNT_OUT_W'(total);
    end
    if ((state_r == S_RESP) && (!out_vld_r || out_tready)) begin
      out_cnt_r <= res_cnt_r;
      out_sts_r <= res_sts_r;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, out_sts_r, out_cnt_r};

endmodule

`default_nettype wire

// File: sim/sliding_window_distinct_count_top_test.sv
// Self-checking bench for sliding_window_distinct_count_top: directed table,
// then random command phases at several length settings, checked against a
// local window/count predictor. Depends on swdc_pkg and the top-level RTL.
`timescale 1ns / 1ps

module sliding_window_distinct_count_top_test;
  import swdc_pkg::*;

  localparam int DEPTH          = ARRAY_DEPTH_DEF;
  localparam int VRANGE         = VALUE_RANGE_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // quiet cycles allowed: covers the reset sweep and the widest query (both ends
  // swept across the store), plus stalls
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_ITEMS    = 80;
  localparam int NUM_PHASES     = 10;
  localparam int NUM_DIRECTED   = 24;

  // one command word, fields in tdata order plus the op
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    logic [POS_W-1:0] qlo;
    logic [POS_W-1:0] qhi;
  } cmd_t;

  typedef struct packed {
    logic [CNT_OUT_W-1:0] cnt;
    logic [STS_W-1:0]     sts;
  } answer_t;

  typedef struct packed {
    cmd_t    cmd;
    logic    typed;   // 1: answer below is the expected one
    answer_t ans;
  } dir_row_t;

  // directed words; untyped rows are checked against the predictor
  dir_row_t directed_rows [NUM_DIRECTED] = '{
    '{'{OP_QUERY, 11'd0,    10'd0,     11'd1,    11'd0   }, 1'b1, '{11'd0, STS_OK}},
    '{'{OP_QUERY, 11'd0,    10'd0,     11'd1,    11'd1024}, 1'b1, '{11'd1, STS_OK}},
    '{'{OP_WRITE, 11'd5,    10'd7,     11'd0,    11'd0   }, 1'b1, '{11'd0, STS_REJECT}},
    '{'{OP_CLEAR, 11'd0,    10'd0,     11'd0,    11'd0   }, 1'b1, '{11'd0, STS_OK}},
    '{'{OP_WRITE, 11'd0,    10'd1,     11'd0,    11'd0   }, 1'b1, '{11'd0, STS_BOUNDS}},
    '{'{OP_WRITE, 11'd1025, 10'd1,     11'd0,    11'd0   }, 1'b1, '{11'd0, STS_BOUNDS}},
    '{'{OP_WRITE, 11'd2047, 10'd1023,  11'd0,    11'd0   }, 1'b1, '{11'd0, STS_BOUNDS}},
    '{'{OP_WRITE, 11'd1024, 10'd1023,  11'd0,    11'd0   }, 1'b1, '{11'd0, STS_OK}},
    '{'{OP_WRITE, 11'd1,    10'd1023,  11'd0,    11'd0   }, 1'b1, '{11'd0, STS_OK}},
    '{'{OP_WRITE, 11'd2,    10'h155,   11'd0,    11'd0   }, 1'b1, '{11'd0, STS_OK}},
    '{'{OP_WRITE, 11'd3,    10'h2AA,   11'd0,    11'd0   }, 1'b1, '{11'd0, STS_OK}},
    '{'{OP_QUERY, 11'd0,    10'd0,     11'd1,    11'd3   }, 1'b0, '{11'd0, STS_OK}},
    '{'{OP_WRITE, 11'd2,    10'd0,     11'd0,    11'd0   }, 1'b1, '{11'd0, STS_REJECT}},
    '{'{OP_QUERY, 11'd0,    10'd0,     11'd0,    11'd5   }, 1'b1, '{11'd0, STS_BOUNDS}},
    '{'{OP_QUERY, 11'd0,    10'd0,     11'd5,    11'd3   }, 1'b1, '{11'd0, STS_BOUNDS}},
    '{'{OP_QUERY, 11'd0,    10'd0,     11'd1,    11'd1025}, 1'b1, '{11'd0, STS_BOUNDS}},
    '{'{OP_QUERY, 11'd0,    10'd0,     11'd2047, 11'd2047}, 1'b1, '{11'd0, STS_BOUNDS}},
    '{'{OP_UNUSED, 11'd2047, 10'd1023, 11'd2047, 11'd2047}, 1'b1, '{11'd0, STS_BOUNDS}},
    '{'{OP_QUERY, 11'd0,    10'd0,     11'd1024, 11'd1024}, 1'b0, '{11'd0, STS_OK}},
    '{'{OP_QUERY, 11'd0,    10'd0,     11'd1,    11'd1024}, 1'b0, '{11'd0, STS_OK}},
    '{'{OP_QUERY, 11'd0,    10'd0,     11'd1025, 11'd1024}, 1'b1, '{11'd0, STS_OK}},
    '{'{OP_CLEAR, 11'd0,    10'd0,     11'd0,    11'd0   }, 1'b1, '{11'd0, STS_OK}},
    '{'{OP_QUERY, 11'd0,    10'd0,     11'd2,    11'd3   }, 1'b0, '{11'd0, STS_OK}},
    '{'{OP_WRITE, 11'd1024, 10'd0,     11'd0,    11'd0   }, 1'b1, '{11'd0, STS_OK}}
  };

  // length settings per random phase: small most of the time, extremes included;
  // 1024 -> 2047 -> 5 lowers the length under a wide window
  int phase_lengths [NUM_PHASES] = '{16, 64, 1024, 2047, 5, 1, 0, 300, 1024, 16};

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [OP_W-1:0]        in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en;
  logic [POS_W-1:0]       cfg_wr_data;

  sliding_window_distinct_count_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // ---------------------------------------------------------------------------
  // Window predictor: own copy of the element store, per-value counts, window
  // ends, running distinct total and the length register.
  // ---------------------------------------------------------------------------
  logic [VAL_W-1:0]     shadow_elems  [DEPTH];
  logic [CNT_OUT_W-1:0] shadow_counts [VRANGE];
  int                   win_lo;
  int                   win_hi;
  int                   distinct_now;
  int                   length_reg;

  answer_t answer_q [$];      // expected results, oldest first
  int      mismatches;
  int      hold_req;          // bumped by stimulus to ask for a long drain hold
  int      hold_done;         // caught up by the receiver when the hold ends
  bit      sender_steady;     // no gaps on the input side

  function automatic int usable_length();
    return (length_reg < DEPTH) ? length_reg : DEPTH;
  endfunction

  function automatic void window_take(int p);
    logic [VAL_W-1:0] v;
    v = shadow_elems[p-1];
    if (shadow_counts[v] == '0) distinct_now++;
    shadow_counts[v]++;
  endfunction

  function automatic void window_drop(int p);
    logic [VAL_W-1:0] v;
    v = shadow_elems[p-1];
    if (shadow_counts[v] != '0) begin
      shadow_counts[v]--;
      if (shadow_counts[v] == '0) distinct_now--;
    end
  endfunction

  // applies one command to the shadow state and returns its result
  function automatic answer_t predict_distinct(cmd_t c);
    answer_t a;
    int      lo;
    int      hi;
    int      p;
    a  = '0;
    lo = c.qlo;
    hi = c.qhi;
    p  = c.pos;
    case (c.op)
      OP_WRITE: begin
        if (p < 1 || p > usable_length()) a.sts = STS_BOUNDS;
        else if (p >= win_lo && p <= win_hi) a.sts = STS_REJECT;
        else shadow_elems[p-1] = c.val;
      end
      OP_QUERY: begin
        if (lo < 1 || lo > hi + 1 || hi > usable_length()) begin
          a.sts = STS_BOUNDS;
        end else begin
          // grow both ends first, then shrink
          while (lo < win_lo) begin win_lo--; window_take(win_lo); end
          while (hi > win_hi) begin win_hi++; window_take(win_hi); end
          while (lo > win_lo) begin window_drop(win_lo); win_lo++; end
          while (hi < win_hi) begin window_drop(win_hi); win_hi--; end
          a.cnt = distinct_now[CNT_OUT_W-1:0];
        end
      end
      OP_CLEAR: begin
        foreach (shadow_counts[i]) shadow_counts[i] = '0;
        win_lo       = 1;
        win_hi       = 0;
        distinct_now = 0;
      end
      default: a.sts = STS_BOUNDS;
    endcase
    return a;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // random command: mostly writes and queries that walk the window a short
  // way (Mo-like), some wide jumps, clears and malformed words
  function automatic cmd_t random_cmd();
    cmd_t c;
    int   k;
    int   lim;
    int   lo;
    int   hi;
    c   = '0;
    k   = $urandom_range(0, 99);
    lim = usable_length();
    c.val = VAL_W'($urandom);
    if (k < 38) begin
      c.op  = OP_WRITE;
      c.pos = (lim > 0) ? POS_W'($urandom_range(1, lim)) : POS_W'($urandom);
    end else if (k < 80) begin
      c.op = OP_QUERY;
      if (lim == 0) begin
        lo = 1;
        hi = 0;
      end else if ($urandom_range(0, 9) == 0) begin
        lo = $urandom_range(1, lim);
        hi = $urandom_range(lo - 1, lim);
      end else begin
        hi = win_hi + $urandom_range(0, 16) - 8;
        lo = win_lo + $urandom_range(0, 16) - 8;
        if (hi > lim) hi = lim;
        if (hi < 0) hi = 0;
        if (lo > hi + 1) lo = hi + 1;
        if (lo < 1) lo = 1;
      end
      c.qlo = POS_W'(lo);
      c.qhi = POS_W'(hi);
    end else if (k < 85) begin
      c.op = OP_CLEAR;
    end else begin
      // malformed: unused op, stray write positions, raw query bounds
      case ($urandom_range(0, 2))
        0:       c.op = OP_UNUSED;
        1:       c.op = OP_WRITE;
        default: c.op = OP_QUERY;
      endcase
      c.pos = POS_W'($urandom);
      c.qlo = POS_W'($urandom);
      c.qhi = POS_W'($urandom);
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Input side. Called at a falling edge; returns at the falling edge after the
  // word was taken. Prediction happens at the accepting rising edge.
  // ---------------------------------------------------------------------------
  task automatic send_word(input cmd_t c, input logic typed, input answer_t typed_ans);
    int      gap;
    answer_t got;
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c.op;
    in_tdata  <= {5'b0, c.qhi, c.qlo, c.val, c.pos};
    do @(posedge clk); while (!in_tready);
    got = predict_distinct(c);
    answer_q.insert(answer_q.size(), typed ? typed_ans : got);
    @(negedge clk);
  endtask

  // block idle: nothing outstanding, then a few spare cycles
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (answer_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    rst_n         = 1'b0;
    hold_req      = 0;
    sender_steady = 1'b0;
    foreach (shadow_elems[i]) shadow_elems[i] = '0;
    foreach (shadow_counts[i]) shadow_counts[i] = '0;
    win_lo       = 1;
    win_hi       = 0;
    distinct_now = 0;
    length_reg   = LEN_RESET;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table at the reset length
    foreach (directed_rows[i])
      send_word(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].ans);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= POS_W'(phase_lengths[ph]);
      length_reg   = phase_lengths[ph];
      @(negedge clk);
      cfg_wr_en <= 1'b0;
      @(negedge clk);
      // first phase: long drain hold while words keep coming, fills the block
      if (ph == 0) hold_req++;
      sender_steady = (ph % 3 == 1);
      repeat (PHASE_ITEMS) send_word(random_cmd(), 1'b0, '0);
    end

    wait_drained();
    repeat (32) @(negedge clk);
    if (mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Output side: random stalls, steady stretches, one long hold on request
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    int steady_left;
    out_tready  = 1'b0;
    hold_done   = 0;
    stall       = 0;
    steady_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = hold_req;
      end else if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
        if (steady_left > 0) steady_left--;
        else if ($urandom_range(0, 199) == 0) steady_left = $urandom_range(50, 300);
        else if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: each taken word against the oldest expectation
  // ---------------------------------------------------------------------------
  initial mismatches = 0;

  always @(posedge clk) begin
    answer_t want;
    if (out_tvalid && out_tready) begin
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got count %0d status %0d",
                 $time, out_tdata[10:0], out_tdata[12:11]);
        mismatches++;
      end else begin
        want = answer_q.pop_front();
        if (out_tdata[10:0] != want.cnt) begin
          $display("%0t: distinct_count mismatch, expected %0d, got %0d",
                   $time, want.cnt, out_tdata[10:0]);
          mismatches++;
        end
        if (out_tdata[12:11] != want.sts) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want.sts, out_tdata[12:11]);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: cycles with no word moving on either side
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, answer_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
